// File: rtl/mwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwl_pkg
// Shared types and constants for the minimal wall length block.
// ----------------------------------------------------------------------------
package mwl_pkg;

  localparam int AXES        = 3;
  localparam int COORD_W     = 32;
  localparam int LEN_W       = 31;
  localparam int SQ_W        = 2 * LEN_W;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 32;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 31'd6554;

  typedef logic [COORD_W-1:0] coord_t;

  // payload that rides alongside the arithmetic stages
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] a;
    logic [AXES-1:0][COORD_W-1:0] b;
    logic [AXES-1:0]              neg;
    logic [AXES-1:0][LEN_W-1:0]   mag;
    logic                         act;
    logic                         degen;
  } side_t;

endpackage

// File: rtl/minimal_wall_length_enforce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_wall_length_enforce
// Pushes the two ends of a short wall apart to the configured minimum length.
//
//   channel | ports                          | direction
//   input   | in_valid, in_stall, in_*       | one wall in
//   result  | out_valid, out_stall, out_*    | one wall out
//   config  | cfg_wr_en, cfg_min_length      | min length write
//
// One item per cycle unless an output stall holds it; the pipeline holds
// the 32-stage square root and 32-stage divider lanes (one result bit per stage).
// Synchronous active-low reset clears the valid bits; min_length resets
// to 6554. A stall on the output while out_valid is high freezes the whole
// pipeline and raises in_stall in the same cycle, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module minimal_wall_length_enforce import mwl_pkg::*; #(
  parameter int DIMENSION = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_min_length,
  input  logic             in_valid,
  output logic             in_stall,
  input  coord_t           in_first_x,
  input  coord_t           in_first_y,
  input  coord_t           in_first_z,
  input  coord_t           in_second_x,
  input  coord_t           in_second_y,
  input  coord_t           in_second_z,
  output logic             out_valid,
  input  logic             out_stall,
  output coord_t           out_new_first_x,
  output coord_t           out_new_first_y,
  output coord_t           out_new_first_z,
  output coord_t           out_new_second_x,
  output coord_t           out_new_second_y,
  output coord_t           out_new_second_z,
  output logic             out_adjusted,
  output logic             out_degenerate
);

  logic             en;
  logic [LEN_W-1:0] min_len_r;
  logic             out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_min_length;
    end
  end

  // stage 1: differences
  logic [AXES-1:0][COORD_W-1:0] in_a, in_b;
  logic [AXES-1:0][COORD_W:0]   mag_in;
  logic [AXES-1:0]              neg_in;

  assign in_a = {in_first_z, in_first_y, in_first_x};
  assign in_b = {in_second_z, in_second_y, in_second_x};

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [COORD_W:0] d;
      d = {in_b[i][COORD_W-1], in_b[i]} - {in_a[i][COORD_W-1], in_a[i]};
      neg_in[i] = d[COORD_W];
      mag_in[i] = d[COORD_W] ? (~d + 1'b1) : d;
    end
  end

  logic                         v1_r;
  logic [AXES-1:0][COORD_W-1:0] a1_r, b1_r;
  logic [AXES-1:0][COORD_W:0]   mag1_r;
  logic [AXES-1:0]              neg1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= in_a;
      b1_r   <= in_b;
      mag1_r <= mag_in;
      neg1_r <= neg_in;
    end
  end

  // stage 2: squares and long axis test
  logic                        v2_r, long2_r;
  logic [AXES-1:0][SQ_W-1:0]   sq2_r;
  logic [SQ_W-1:0]             mm2_r;
  side_t                       side2_r;
  logic                        long_nxt;
  side_t                       side2_nxt;

  always_comb begin
    long_nxt  = 1'b0;
    side2_nxt = '0;
    side2_nxt.a   = a1_r;
    side2_nxt.b   = b1_r;
    side2_nxt.neg = neg1_r;
    for (int i = 0; i < AXES; i++) begin
      if (i < DIMENSION) begin
        if (mag1_r[i] >= {2'b00, min_len_r}) long_nxt = 1'b1;
        side2_nxt.mag[i] = mag1_r[i][LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      long2_r <= long_nxt;
      side2_r <= side2_nxt;
      mm2_r   <= min_len_r * min_len_r;
      for (int i = 0; i < AXES; i++) begin
        sq2_r[i] <= side2_nxt.mag[i] * side2_nxt.mag[i];
      end
    end
  end

  // stage 3: sum of squares
  logic             v3_r, long3_r;
  logic [SUM_W-1:0] s3_r;
  logic [SQ_W-1:0]  mm3_r;
  side_t            side3_r;
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < AXES; i++) begin
      sum_nxt = sum_nxt + {{(SUM_W-SQ_W){1'b0}}, sq2_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= sum_nxt;
      long3_r <= long2_r;
      mm3_r   <= mm2_r;
      side3_r <= side2_r;
    end
  end

  // stage 4: short and degenerate flags
  logic             v4_r;
  logic [SUM_W-1:0] s4_r;
  side_t            side4_r;
  side_t            side4_nxt;

  always_comb begin
    side4_nxt       = side3_r;
    side4_nxt.act   = !long3_r && (s3_r != '0) &&
                      (s3_r < {{(SUM_W-SQ_W){1'b0}}, mm3_r});
    side4_nxt.degen = !long3_r && (s3_r == '0) && (min_len_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s3_r;
      side4_r <= side4_nxt;
    end
  end

  // square root, one root bit per stage
  logic [SQRT_STEPS-1:0] rt_v_r;
  logic [ROOT_W+2:0]     rt_rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0]     rt_root_r [SQRT_STEPS];
  logic [SUM_W-1:0]      rt_src_r  [SQRT_STEPS];
  side_t                 rt_side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [ROOT_W+2:0] rem_i, rem_sh, trial;
    logic [ROOT_W-1:0] root_i;
    logic [SUM_W-1:0]  src_i;
    side_t             side_i;
    logic              v_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign src_i  = s4_r;
      assign side_i = side4_r;
      assign v_i    = v4_r;
    end else begin : g_next
      assign rem_i  = rt_rem_r[k-1];
      assign root_i = rt_root_r[k-1];
      assign src_i  = rt_src_r[k-1];
      assign side_i = rt_side_r[k-1];
      assign v_i    = rt_v_r[k-1];
    end

    assign rem_sh = {rem_i[ROOT_W:0], src_i[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k] <= 1'b0;
      end else if (en) begin
        rt_v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rt_rem_r[k]  <= rem_sh - trial;
          rt_root_r[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rt_rem_r[k]  <= rem_sh;
          rt_root_r[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
        rt_src_r[k]  <= {src_i[SUM_W-3:0], 2'b00};
        rt_side_r[k] <= side_i;
      end
    end
  end

  // stage 5: shortfall times axis magnitude
  logic [LEN_W-1:0]          root_len;
  logic [LEN_W-1:0]          gap;
  logic                      v5_r;
  logic [AXES-1:0][SQ_W-1:0] prod5_r;
  logic [LEN_W-1:0]          dist5_r;
  side_t                     side5_r;

  assign root_len = rt_root_r[SQRT_STEPS-1][LEN_W-1:0];
  assign gap      = min_len_r - root_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= rt_v_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist5_r <= root_len;
      side5_r <= rt_side_r[SQRT_STEPS-1];
      for (int i = 0; i < AXES; i++) begin
        prod5_r[i] <= gap * rt_side_r[SQRT_STEPS-1].mag[i];
      end
    end
  end

  // stage 6: rounding term and divisor
  logic                       v6_r;
  logic [AXES-1:0][SQ_W:0]    num6_r;
  logic [LEN_W:0]             den6_r;
  side_t                      side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den6_r  <= {dist5_r, 1'b0};
      side6_r <= side5_r;
      for (int i = 0; i < AXES; i++) begin
        num6_r[i] <= {1'b0, prod5_r[i]} + {{(SQ_W-LEN_W+1){1'b0}}, dist5_r};
      end
    end
  end

  // restoring divider, one quotient bit per stage on each axis
  logic [DIV_STEPS-1:0]           dv_v_r;
  logic [AXES-1:0][LEN_W:0]       dv_rem_r [DIV_STEPS];
  logic [AXES-1:0][DIV_STEPS-1:0] dv_q_r   [DIV_STEPS];
  logic [AXES-1:0][DIV_STEPS-1:0] dv_num_r [DIV_STEPS];
  logic [LEN_W:0]                 dv_den_r [DIV_STEPS];
  side_t                          dv_side_r[DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [AXES-1:0][LEN_W:0]       rem_i;
    logic [AXES-1:0][DIV_STEPS-1:0] q_i, num_i;
    logic [LEN_W:0]                 den_i;
    side_t                          side_i;
    logic                           v_i;

    if (j == 0) begin : g_first
      for (genvar i = 0; i < AXES; i++) begin : g_ax
        assign rem_i[i] = {1'b0, num6_r[i][SQ_W -: LEN_W]};
        assign num_i[i] = num6_r[i][DIV_STEPS-1:0];
      end
      assign q_i    = '0;
      assign den_i  = den6_r;
      assign side_i = side6_r;
      assign v_i    = v6_r;
    end else begin : g_next
      assign rem_i  = dv_rem_r[j-1];
      assign num_i  = dv_num_r[j-1];
      assign q_i    = dv_q_r[j-1];
      assign den_i  = dv_den_r[j-1];
      assign side_i = dv_side_r[j-1];
      assign v_i    = dv_v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < AXES; i++) begin
          logic [LEN_W+1:0] t;
          t = {rem_i[i], num_i[i][DIV_STEPS-1-j]};
          if (t >= {1'b0, den_i}) begin
            dv_rem_r[j][i] <= (LEN_W+1)'(t - {1'b0, den_i});
            dv_q_r[j][i]   <= {q_i[i][DIV_STEPS-2:0], 1'b1};
          end else begin
            dv_rem_r[j][i] <= t[LEN_W:0];
            dv_q_r[j][i]   <= {q_i[i][DIV_STEPS-2:0], 1'b0};
          end
        end
        dv_num_r[j]  <= num_i;
        dv_den_r[j]  <= den_i;
        dv_side_r[j] <= side_i;
      end
    end
  end

  // final stage: apply offsets with saturation
  side_t                        fin;
  logic [AXES-1:0][COORD_W-1:0] na_nxt, nb_nxt;
  logic [AXES-1:0][COORD_W-1:0] na_r, nb_r;
  logic                         adj_r, degen_r;

  assign fin = dv_side_r[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [COORD_W+1:0] off, ra, rb;
      off = '0;
      if (fin.act && (i < DIMENSION)) begin
        off = {2'b00, dv_q_r[DIV_STEPS-1][i]};
        if (fin.neg[i]) off = ~off + 1'b1;
      end
      ra = {{2{fin.a[i][COORD_W-1]}}, fin.a[i]} - off;
      rb = {{2{fin.b[i][COORD_W-1]}}, fin.b[i]} + off;
      if (ra[COORD_W+1] && !(&ra[COORD_W:COORD_W-1])) begin
        na_nxt[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else if (!ra[COORD_W+1] && (|ra[COORD_W:COORD_W-1])) begin
        na_nxt[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        na_nxt[i] = ra[COORD_W-1:0];
      end
      if (rb[COORD_W+1] && !(&rb[COORD_W:COORD_W-1])) begin
        nb_nxt[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else if (!rb[COORD_W+1] && (|rb[COORD_W:COORD_W-1])) begin
        nb_nxt[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        nb_nxt[i] = rb[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r    <= na_nxt;
      nb_r    <= nb_nxt;
      adj_r   <= fin.act;
      degen_r <= fin.degen;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_first_x  = na_r[0];
  assign out_new_first_y  = na_r[1];
  assign out_new_first_z  = na_r[2];
  assign out_new_second_x = nb_r[0];
  assign out_new_second_y = nb_r[1];
  assign out_new_second_z = nb_r[2];
  assign out_adjusted     = adj_r;
  assign out_degenerate   = degen_r;

endmodule

// File: tb/minimal_wall_length_enforce_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_wall_length_enforce_tb
// Self-checking bench for the wall lengthening block: walls are streamed in
// with random gaps and output stalls, each result is compared as a whole
// against an in-bench fixed point predictor across several min_length values.
// ----------------------------------------------------------------------------
module minimal_wall_length_enforce_tb;
  import mwl_pkg::*;

  localparam int LATENCY   = 71;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] p;
    logic [AXES-1:0][COORD_W-1:0] q;
    logic adj;
    logic degen;
  } wall_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_min_length = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_first_x = '0, in_first_y = '0, in_first_z = '0;
  coord_t in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_new_first_x, out_new_first_y, out_new_first_z;
  coord_t out_new_second_x, out_new_second_y, out_new_second_z;
  logic out_adjusted, out_degenerate;

  minimal_wall_length_enforce i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_min_length(cfg_min_length),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_second_z(in_second_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_first_x(out_new_first_x), .out_new_first_y(out_new_first_y),
    .out_new_first_z(out_new_first_z), .out_new_second_x(out_new_second_x),
    .out_new_second_y(out_new_second_y), .out_new_second_z(out_new_second_z),
    .out_adjusted(out_adjusted), .out_degenerate(out_degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [LEN_W-1:0] min_len_model = MIN_LEN_RESET;
  wall_t expected_walls[$];
  int mismatches = 0;
  int walls_sent = 0;
  int walls_checked = 0;
  int walls_adjusted = 0;
  int walls_degen = 0;
  int idle_pct = 35;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [COORD_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic wall_t lengthen_wall(wall_t w);
    longint a[AXES], b[AXES], d[AXES], off[AXES];
    longint unsigned mag[AXES];
    longint unsigned m, s, root_len, gap, den, qv;
    bit long_axis;
    wall_t r;
    m = min_len_model;
    s = 0;
    long_axis = 0;
    r = '0;
    for (int i = 0; i < AXES; i++) begin
      a[i] = longint'(signed'(w.p[i]));
      b[i] = longint'(signed'(w.q[i]));
      d[i] = b[i] - a[i];
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      off[i] = 0;
      if (mag[i] >= m) long_axis = 1;
    end
    if (!long_axis) begin
      for (int i = 0; i < AXES; i++) s += mag[i] * mag[i];
      if (s == 0) begin
        r.degen = (m > 0);
      end else if (s < m * m) begin
        root_len = int_sqrt(s);
        gap = m - root_len;
        den = 2 * root_len;
        r.adj = 1'b1;
        for (int i = 0; i < AXES; i++) begin
          qv = (gap * mag[i] + root_len) / den;
          off[i] = d[i] < 0 ? -longint'(qv) : longint'(qv);
        end
      end
    end
    for (int i = 0; i < AXES; i++) begin
      r.p[i] = clamp32(a[i] - off[i]);
      r.q[i] = clamp32(b[i] + off[i]);
    end
    return r;
  endfunction

  task automatic send_wall(wall_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_first_z, in_first_y, in_first_x} <= w.p;
    {in_second_z, in_second_y, in_second_x} <= w.q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_walls.push_back(lengthen_wall(w));
    walls_sent++;
  endtask

  task automatic drain_walls();
    in_valid <= 1'b0;
    while (expected_walls.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_min_length(logic [LEN_W-1:0] v);
    drain_walls();
    cfg_wr_en <= 1'b1;
    cfg_min_length <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_len_model = v;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
                                   : 32'h80000000 + $urandom_range(255);
      default: return $urandom_range(1) ? $urandom_range(32'h000fffff)
                                         : -$urandom_range(32'h000fffff);
    endcase
  endfunction

  // near walls: second vertex within a box scaled to min_length
  function automatic wall_t rand_wall(int near_pct);
    wall_t w;
    int unsigned spread;
    for (int i = 0; i < AXES; i++) w.p[i] = rand_coord();
    spread = (min_len_model >> $urandom_range(6)) + 1;
    for (int i = 0; i < AXES; i++) begin
      if ($urandom_range(99) < near_pct)
        w.q[i] = w.p[i] + ($urandom_range(1) ? $urandom_range(spread)
                                             : -$urandom_range(spread));
      else
        w.q[i] = rand_coord();
    end
    if ($urandom_range(49) == 0) w.q = w.p;
    return w;
  endfunction

  task automatic test_directed();
    wall_t w;
    w.p = '0; w.q = '0; send_wall(w);
    w.p = {32'd5, 32'd7, 32'd9}; w.q = w.p; send_wall(w);
    w.p = '0; w.q = {32'd0, 32'd0, 32'd100}; send_wall(w);
    w.q = {32'd0, 32'd0, -32'd1}; send_wall(w);
    w.p = {3{32'h7fffffff}};
    w.q = {32'h7fffffff, 32'h7fffffff, 32'h7ffffff0}; send_wall(w);
    w.p = {3{32'h80000000}};
    w.q = {32'h80000000, 32'h80000010, 32'h80000001}; send_wall(w);
    w.p = {3{32'h80000000}}; w.q = {3{32'h7fffffff}}; send_wall(w);
    w.p = {3{32'h7fffffff}}; w.q = {3{32'h80000000}}; send_wall(w);
    w.p = {32'd0, 32'd0, 32'd0}; w.q = {32'd0, 32'd6554, 32'd0}; send_wall(w);
    w.q = {32'd1, 32'd2, 32'd3}; send_wall(w);
    w.p = {32'hffff0000, 32'h10000, 32'h5};
    w.q = {32'hffff0100, 32'h10010, 32'h2}; send_wall(w);
    w.p = {32'hffffffff, 32'h0, 32'h0};
    w.q = {32'h00000000, 32'hffffffff, 32'h1}; send_wall(w);
  endtask

  task automatic test_random(int count, int near_pct);
    for (int n = 0; n < count; n++) send_wall(rand_wall(near_pct));
  endtask

  task automatic test_config_sweep();
    logic [LEN_W-1:0] lens[6];
    lens = '{31'd0, 31'd1, 31'd65536, 31'h7fffffff, 31'h00123456, MIN_LEN_RESET};
    foreach (lens[k]) begin
      write_min_length(lens[k]);
      test_directed();
      test_random(k == 0 ? 60 : 120, 85);
    end
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random(300, 85);
    idle_pct = 35;
  endtask

  task automatic test_pause_until_empty();
    test_random(20, 90);
    drain_walls();
    test_random(20, 90);
  endtask

  task automatic test_bulk();
    write_min_length(31'h00400000);
    test_random(300, 75);
    write_min_length(31'h00010000 + $urandom_range(31'h3ffff));
    test_random(280, 80);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (idle_pct != 0) && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    wall_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.p = {out_new_first_z, out_new_first_y, out_new_first_x};
      got.q = {out_new_second_z, out_new_second_y, out_new_second_x};
      got.adj = out_adjusted;
      got.degen = out_degenerate;
      if (expected_walls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item at %0t", $realtime);
      end else begin
        want = expected_walls.pop_front();
        walls_checked++;
        walls_adjusted += want.adj;
        walls_degen += want.degen;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp p=%h q=%h adj=%b deg=%b",
                      " got p=%h q=%h adj=%b deg=%b"},
                     $realtime, want.p, want.q, want.adj, want.degen,
                     got.p, got.q, got.adj, got.degen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired with %0d items outstanding", expected_walls.size());
      $display("FAIL minimal_wall_length_enforce");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100, 85);
    test_config_sweep();
    test_no_idle();
    test_pause_until_empty();
    test_bulk();
    drain_walls();
    $display("checked %0d of %0d walls, %0d lengthened, %0d degenerate, %0d mismatches",
             walls_checked, walls_sent, walls_adjusted, walls_degen, mismatches);
    if (mismatches == 0 && expected_walls.size() == 0) begin
      $display("PASS minimal_wall_length_enforce");
    end else begin
      $display("FAIL minimal_wall_length_enforce");
    end
    $finish;
  end

endmodule

// File: minimal_wall_length_enforce.f
rtl/mwl_pkg.sv
rtl/minimal_wall_length_enforce.sv
tb/minimal_wall_length_enforce_tb.sv
